@@ hw/rtl/sbus_frame_decoder_assert.svh @@
// Assertion helpers for the checker of the frame decoder.
`ifndef SBUS_FRAME_DECODER_ASSERT_SVH
`define SBUS_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SBF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SBF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ hw/rtl/sbf_pkg.sv @@
package sbf_pkg;

  localparam logic [7:0] START_BYTE = 8'h0F;
  localparam int PAYLOAD_LEN = 22;
  localparam int PAYLOAD_W = PAYLOAD_LEN * 8;
  localparam int COUNT_W = 5;
  localparam logic [7:0] FLAG_MASK = 8'h0C;
  localparam logic [7:0] FLAG_BAD_A = 8'h04;
  localparam logic [7:0] FLAG_BAD_B = 8'h0C;
  localparam logic [7:0] END_BYTE_A = 8'h04;
  localparam logic [7:0] END_BYTE_B = 8'h14;
  localparam logic [7:0] END_BYTE_C = 8'h24;
  localparam logic [7:0] END_BYTE_D = 8'h34;
  localparam int CHAN_W = 11;
  localparam int NUM_CHANNELS = 16;
  localparam int INDEX_W = 4;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_PAYLOAD,
    ST_FLAGS,
    ST_END,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr_count;
    logic load_byte;
    logic load_flags;
    logic shift_out;
  } dp_cmd_t;

  typedef struct packed {
    logic start_hit;
    logic count_last;
    logic end_ok;
    logic flags_ok;
    logic last_chan;
  } dp_stat_t;

  function automatic logic end_byte_ok(input logic [7:0] b);
    return (b == END_BYTE_A) || (b == END_BYTE_B) || (b == END_BYTE_C) || (b == END_BYTE_D);
  endfunction

  function automatic logic flags_good(input logic [7:0] f);
    logic [7:0] m;
    m = f & FLAG_MASK;
    return (m != FLAG_BAD_A) && (m != FLAG_BAD_B);
  endfunction

endpackage

@@ hw/rtl/sbf_rx_if.sv @@
interface sbf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/sbf_chan_if.sv @@
interface sbf_chan_if;
  logic                        valid;
  logic                        ready;
  logic [sbf_pkg::INDEX_W-1:0] channel_index;
  logic [sbf_pkg::CHAN_W-1:0]  channel_value;
  logic [7:0]                  frame_flags;
  logic                        last_channel;

  modport source (output valid, output channel_index, output channel_value,
                  output frame_flags, output last_channel, input ready);
  modport sink (input valid, input channel_index, input channel_value,
                input frame_flags, input last_channel, output ready);
endinterface

@@ hw/rtl/sbf_ctrl.sv @@
module sbf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             rx_valid,
  input  logic             chan_ready,
  input  sbf_pkg::dp_stat_t stat,
  output logic             rx_ready,
  output logic             chan_valid,
  output sbf_pkg::dp_cmd_t cmd
);

  sbf_pkg::state_t state;
  sbf_pkg::state_t state_next;
  logic rx_fire;
  logic chan_fire;

  assign rx_ready   = (state != sbf_pkg::ST_EMIT);
  assign chan_valid = (state == sbf_pkg::ST_EMIT);
  assign rx_fire    = rx_valid && rx_ready;
  assign chan_fire  = chan_valid && chan_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbf_pkg::ST_WAIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sbf_pkg::ST_WAIT: begin
        if (rx_fire && stat.start_hit) state_next = sbf_pkg::ST_PAYLOAD;
      end
      sbf_pkg::ST_PAYLOAD: begin
        if (rx_fire && stat.count_last) state_next = sbf_pkg::ST_FLAGS;
      end
      sbf_pkg::ST_FLAGS: begin
        if (rx_fire) state_next = sbf_pkg::ST_END;
      end
      sbf_pkg::ST_END: begin
        if (rx_fire) begin
          state_next = (stat.end_ok && stat.flags_ok) ? sbf_pkg::ST_EMIT : sbf_pkg::ST_WAIT;
        end
      end
      sbf_pkg::ST_EMIT: begin
        if (chan_fire && stat.last_chan) state_next = sbf_pkg::ST_WAIT;
      end
      default: state_next = sbf_pkg::ST_WAIT;
    endcase
  end

  always_comb begin
    cmd.clr_count  = 1'b0;
    cmd.load_byte  = 1'b0;
    cmd.load_flags = 1'b0;
    cmd.shift_out  = 1'b0;
    case (state)
      sbf_pkg::ST_WAIT:    cmd.clr_count  = rx_fire && stat.start_hit;
      sbf_pkg::ST_PAYLOAD: cmd.load_byte  = rx_fire;
      sbf_pkg::ST_FLAGS:   cmd.load_flags = rx_fire;
      sbf_pkg::ST_END:     cmd.clr_count  = 1'b0;
      sbf_pkg::ST_EMIT:    cmd.shift_out  = chan_fire;
      default:             cmd.clr_count  = 1'b0;
    endcase
  end

endmodule

@@ hw/rtl/sbf_dpath.sv @@
module sbf_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [7:0]                  rx_byte,
  input  sbf_pkg::dp_cmd_t            cmd,
  output sbf_pkg::dp_stat_t           stat,
  output logic [sbf_pkg::INDEX_W-1:0] channel_index,
  output logic [sbf_pkg::CHAN_W-1:0]  channel_value,
  output logic [7:0]                  frame_flags,
  output logic                        last_channel
);

  // Payload shift line: bytes enter at the top, so byte 0 ends at the bottom
  // and channel k sits at bits 11k..11k+10 once the frame is in.
  logic [sbf_pkg::PAYLOAD_W-1:0] payload_sr;
  logic [sbf_pkg::COUNT_W-1:0]   byte_count;
  logic [7:0]                    flag_byte;
  logic [sbf_pkg::INDEX_W-1:0]   emit_index;

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      payload_sr <= {rx_byte, payload_sr[sbf_pkg::PAYLOAD_W-1:8]};
    end else if (cmd.shift_out) begin
      payload_sr <= {{sbf_pkg::CHAN_W{1'b0}}, payload_sr[sbf_pkg::PAYLOAD_W-1:sbf_pkg::CHAN_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      flag_byte  <= '0;
      emit_index <= '0;
    end else begin
      if (cmd.clr_count) begin
        byte_count <= '0;
      end else if (cmd.load_byte) begin
        byte_count <= byte_count + 1'b1;
      end
      if (cmd.load_flags) flag_byte <= rx_byte;
      // Wraps back to channel 0 after the last beat.
      if (cmd.shift_out) emit_index <= emit_index + 1'b1;
    end
  end

  assign stat.start_hit  = (rx_byte == sbf_pkg::START_BYTE);
  assign stat.count_last = (byte_count == sbf_pkg::COUNT_W'(sbf_pkg::PAYLOAD_LEN - 1));
  assign stat.end_ok     = sbf_pkg::end_byte_ok(rx_byte);
  assign stat.flags_ok   = sbf_pkg::flags_good(flag_byte);
  assign stat.last_chan  = (emit_index == sbf_pkg::INDEX_W'(sbf_pkg::NUM_CHANNELS - 1));

  assign channel_index = emit_index;
  assign channel_value = payload_sr[sbf_pkg::CHAN_W-1:0];
  assign frame_flags   = flag_byte;
  assign last_channel  = stat.last_chan;

endmodule

@@ hw/rtl/sbus_frame_decoder.sv @@
// SBUS frame decoder. Takes one received serial byte per beat on rx, hunts
// for the start byte 0x0F, stores the 22 payload bytes that follow, then the
// flags byte, then checks the end byte. A frame is kept when the end byte is
// 0x04, 0x14, 0x24 or 0x34 and flags bit 2 is clear; any other frame is
// dropped without a trace, and a start byte value inside a frame is plain
// data (no resync). A kept frame goes out on channels as a run of 16 beats,
// channel 0 first, each carrying the 11-bit channel unpacked little-endian
// from the payload, the frame's flags byte, and last_channel on channel 15.
// The rx side is ready whenever no output run is going on. The end byte of a
// kept frame starts the run; rx stays low until the 16th beat has been taken,
// and the run stalls while channels.ready is low. The run is paced by the
// single payload shift register, which moves 11 bits per beat taken.
module sbus_frame_decoder (
  input  logic           clk,
  input  logic           rst,
  sbf_rx_if.sink         rx,
  sbf_chan_if.source     channels
);

  sbf_pkg::dp_cmd_t  cmd;
  sbf_pkg::dp_stat_t stat;

  // Sequence the frame: hunt, payload, flags, end byte, emit.
  sbf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx.valid),
    .chan_ready (channels.ready),
    .stat       (stat),
    .rx_ready   (rx.ready),
    .chan_valid (channels.valid),
    .cmd        (cmd)
  );

  // Hold the payload, counters and flags; drive the output beat.
  sbf_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .rx_byte       (rx.rx_byte),
    .cmd           (cmd),
    .stat          (stat),
    .channel_index (channels.channel_index),
    .channel_value (channels.channel_value),
    .frame_flags   (channels.frame_flags),
    .last_channel  (channels.last_channel)
  );

endmodule

@@ hw/rtl/sbf_checker.sv @@
`include "sbus_frame_decoder_assert.svh"

module sbf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rx_ready,
  input logic                        chan_valid,
  input logic                        chan_ready,
  input logic [sbf_pkg::INDEX_W-1:0] channel_index,
  input logic [sbf_pkg::CHAN_W-1:0]  channel_value,
  input logic                        last_channel
);

  logic chan_fire;
  assign chan_fire = chan_valid && chan_ready;

  `SBF_ASSERT_NEXT(a_stall_hold, clk, rst, chan_valid && !chan_ready, chan_valid && $stable(channel_value) && $stable(channel_index))
  `SBF_ASSERT_IMPL(a_no_rx_during_run, clk, rst, chan_valid, !rx_ready)
  `SBF_ASSERT_NEXT(a_run_ends, clk, rst, chan_fire && last_channel, !chan_valid)
  `SBF_ASSERT_NEXT(a_run_steps, clk, rst, chan_fire && !last_channel, chan_valid && (channel_index == $past(channel_index) + 1'b1))

endmodule

bind sbus_frame_decoder sbf_checker u_sbf_checker (
  .clk           (clk),
  .rst           (rst),
  .rx_ready      (rx.ready),
  .chan_valid    (channels.valid),
  .chan_ready    (channels.ready),
  .channel_index (channels.channel_index),
  .channel_value (channels.channel_value),
  .last_channel  (channels.last_channel)
);

@@ dv/sbus_frame_decoder_tb.sv @@
`timescale 1ns / 1ps

module sbus_frame_decoder_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  // One expected channel beat, laid out like the channels payload.
  typedef struct packed {
    logic [sbf_pkg::INDEX_W-1:0] index;
    logic [sbf_pkg::CHAN_W-1:0]  value;
    logic [7:0]                  flags;
    logic                        last;
  } chan_beat_t;

  typedef logic [7:0] payload_t [sbf_pkg::PAYLOAD_LEN];

  logic clk = 1'b0;
  logic rst;

  sbf_rx_if   rx_bus ();
  sbf_chan_if chan_bus ();

  sbus_frame_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx_bus),
    .channels (chan_bus)
  );

  always #6 clk = ~clk;

  // Frame parser mirror: tracks where the block is in the frame and holds
  // the payload and flags of the frame being received.
  sbf_pkg::state_t parse_st = sbf_pkg::ST_WAIT;
  int              payload_cnt = 0;
  payload_t        rx_payload;
  logic [7:0]      rx_flags = 8'h00;

  // Channel beats still owed by the block, oldest first.
  chan_beat_t exp_channels[$];
  chan_beat_t got_beat;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit stall_req = 1'b0;
  int stall_left = 0;

  int cycle_cnt = 0;
  int err_cnt = 0;
  int bytes_sent = 0;
  int counted_items = 0;
  int frames_kept = 0;
  int frames_dropped = 0;
  int beats_checked = 0;

  function automatic bit end_byte_valid(input logic [7:0] b);
    return b == sbf_pkg::END_BYTE_A || b == sbf_pkg::END_BYTE_B ||
           b == sbf_pkg::END_BYTE_C || b == sbf_pkg::END_BYTE_D;
  endfunction

  // Advance the parser mirror by one accepted byte. A good end byte with
  // good flags commits the payload and queues all 16 channel beats.
  task automatic decode_rx_byte(input logic [7:0] b, output bit ignored);
    logic [sbf_pkg::PAYLOAD_W-1:0] committed;
    logic [7:0]                    flag_bits;
    chan_beat_t                    beat;
    ignored = 1'b0;
    case (parse_st)
      sbf_pkg::ST_WAIT: begin
        if (b == sbf_pkg::START_BYTE) begin
          payload_cnt = 0;
          parse_st = sbf_pkg::ST_PAYLOAD;
        end else begin
          ignored = 1'b1;
        end
      end
      sbf_pkg::ST_PAYLOAD: begin
        rx_payload[payload_cnt] = b;
        payload_cnt++;
        if (payload_cnt == sbf_pkg::PAYLOAD_LEN) parse_st = sbf_pkg::ST_FLAGS;
      end
      sbf_pkg::ST_FLAGS: begin
        rx_flags = b;
        parse_st = sbf_pkg::ST_END;
      end
      default: begin
        parse_st = sbf_pkg::ST_WAIT;
        flag_bits = rx_flags & sbf_pkg::FLAG_MASK;
        if (end_byte_valid(b) && flag_bits != sbf_pkg::FLAG_BAD_A &&
            flag_bits != sbf_pkg::FLAG_BAD_B) begin
          // Little-endian bit stream: payload byte i holds bits 8i..8i+7,
          // channel k takes bits 11k..11k+10.
          for (int i = 0; i < sbf_pkg::PAYLOAD_LEN; i++) committed[8*i +: 8] = rx_payload[i];
          for (int k = 0; k < sbf_pkg::NUM_CHANNELS; k++) begin
            beat.index = k[sbf_pkg::INDEX_W-1:0];
            beat.value = committed[sbf_pkg::CHAN_W*k +: sbf_pkg::CHAN_W];
            beat.flags = rx_flags;
            beat.last  = (k == sbf_pkg::NUM_CHANNELS - 1);
            exp_channels.push_back(beat);
          end
          frames_kept++;
        end else begin
          frames_dropped++;
        end
      end
    endcase
  endtask

  // Offer one byte on rx after a random gap and hold it until the block
  // takes it. Valid stays high afterwards so back-to-back beats need no
  // drop in between; the next gap or byte decides at the falling edge.
  task automatic send_byte(input logic [7:0] b);
    bit ignored;
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      rx_bus.valid = 1'b0;
    end
    @(negedge clk);
    rx_bus.valid   = 1'b1;
    rx_bus.rx_byte = b;
    @(posedge clk);
    while (!rx_bus.ready) @(posedge clk);
    decode_rx_byte(b, ignored);
    bytes_sent++;
    if (!ignored) counted_items++;
  endtask

  task automatic send_frame(input payload_t p, input logic [7:0] flags,
                            input logic [7:0] end_b);
    send_byte(sbf_pkg::START_BYTE);
    for (int i = 0; i < sbf_pkg::PAYLOAD_LEN; i++) send_byte(p[i]);
    send_byte(flags);
    send_byte(end_b);
  endtask

  // Drop valid and hold off until every owed channel beat has arrived.
  task automatic wait_drain();
    @(negedge clk);
    rx_bus.valid = 1'b0;
    while (exp_channels.size() != 0) @(posedge clk);
  endtask

  // Mostly random bytes, with a fair share of the extremes and of the start
  // byte value so that payload bytes equal to 0x0F get exercised.
  function automatic payload_t random_payload();
    payload_t p;
    for (int i = 0; i < sbf_pkg::PAYLOAD_LEN; i++) begin
      case ($urandom_range(9))
        0:       p[i] = 8'h00;
        1:       p[i] = 8'hFF;
        2:       p[i] = sbf_pkg::START_BYTE;
        default: p[i] = 8'($urandom_range(255));
      endcase
    end
    return p;
  endfunction

  function automatic logic [7:0] good_end_byte();
    case ($urandom_range(3))
      0:       return sbf_pkg::END_BYTE_A;
      1:       return sbf_pkg::END_BYTE_B;
      2:       return sbf_pkg::END_BYTE_C;
      default: return sbf_pkg::END_BYTE_D;
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == sbf_pkg::START_BYTE) b = ~b;
    return b;
  endfunction

  // Bytes outside a frame must be dropped without a beat.
  task automatic test_noise_ignored();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(sbf_pkg::START_BYTE - 8'h01);
  endtask

  // All-zero and all-ones payloads; flags of zero and with every bit set except
  // bits 2 and 3, and the lowest and highest good end bytes.
  task automatic test_payload_extremes();
    payload_t p;
    foreach (p[i]) p[i] = 8'h00;
    send_frame(p, 8'h00, sbf_pkg::END_BYTE_A);
    foreach (p[i]) p[i] = 8'hFF;
    send_frame(p, 8'hF3, sbf_pkg::END_BYTE_D);
  endtask

  // Remaining good end bytes, with flags bits 3:2 = 10, which is allowed.
  task automatic test_end_byte_variants();
    send_frame(random_payload(), 8'h08, sbf_pkg::END_BYTE_B);
    send_frame(random_payload(), 8'hFB & 8'hFB, sbf_pkg::END_BYTE_C);
  endtask

  // Bad flags (bits 3:2 = 01 and 11) and bad end bytes drop the frame;
  // the good frame after them must still come out intact.
  task automatic test_dropped_frames();
    send_frame(random_payload(), 8'h04, sbf_pkg::END_BYTE_A);
    send_frame(random_payload(), 8'hFF, sbf_pkg::END_BYTE_B);
    send_frame(random_payload(), 8'h00, 8'h00);
    send_frame(random_payload(), 8'h00, 8'hFF);
    send_frame(random_payload(), 8'h01, sbf_pkg::END_BYTE_C);
  endtask

  // A start byte value inside the payload is data, not a resync.
  task automatic test_start_value_in_payload();
    payload_t p;
    foreach (p[i]) p[i] = sbf_pkg::START_BYTE;
    p[0] = 8'hA5;
    send_frame(p, 8'h03, sbf_pkg::END_BYTE_D);
  endtask

  // Random traffic: mostly well-formed frames with random content, the rest
  // dropped frames, cut-off frames and line noise. Runs until item_goal
  // more bytes have gone in.
  task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                     input int item_goal);
    int         stop_at;
    int         kind;
    int         cut_len;
    logic [7:0] flags;
    logic [7:0] end_b;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    stop_at = bytes_sent + item_goal;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(99) < 30) begin
        repeat ($urandom_range(1, 3)) send_byte(noise_byte());
      end
      kind = $urandom_range(99);
      flags = 8'($urandom_range(255));
      flags[2] = 1'b0;
      end_b = good_end_byte();
      if (kind < 70) begin
        send_frame(random_payload(), flags, end_b);
      end else if (kind < 80) begin
        flags[2] = 1'b1;
        send_frame(random_payload(), flags, end_b);
      end else if (kind < 88) begin
        end_b = 8'($urandom_range(255));
        if (end_byte_valid(end_b)) end_b = end_b ^ 8'h01;
        send_frame(random_payload(), flags, end_b);
      end else if (kind < 94) begin
        // Cut a frame short; what follows is swallowed as its remainder.
        cut_len = $urandom_range(1, sbf_pkg::PAYLOAD_LEN + 1);
        send_byte(sbf_pkg::START_BYTE);
        repeat (cut_len) send_byte(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(noise_byte());
      end
    end
    wait_drain();
  endtask

  // Hold channels.ready low for a long stretch while two frames go in back
  // to back, so the block sits in its output run and stalls rx; then pause
  // the sender until every beat has come out.
  task automatic test_backpressure_fill();
    payload_t p;
    wait_drain();
    src_idle_pct = 0;
    stall_req = 1'b1;
    p = random_payload();
    send_frame(p, 8'h00, sbf_pkg::END_BYTE_A);
    send_frame(random_payload(), 8'hF0, sbf_pkg::END_BYTE_C);
    wait_drain();
  endtask

  // Receiver: random ready, overridden by the long hold-off when requested.
  always @(negedge clk) begin
    if (stall_req) begin
      stall_left = STALL_CYCLES;
      stall_req = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      chan_bus.ready = 1'b0;
    end else begin
      chan_bus.ready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Compare every taken channel beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && chan_bus.valid && chan_bus.ready) begin
      if (exp_channels.size() == 0) begin
        $error("unexpected beat: channel_index %0d channel_value %0d",
               chan_bus.channel_index, chan_bus.channel_value);
        err_cnt++;
      end else begin
        got_beat = exp_channels.pop_front();
        beats_checked++;
        if (chan_bus.channel_index !== got_beat.index) begin
          $error("channel_index: expected %0d, actual %0d",
                 got_beat.index, chan_bus.channel_index);
          err_cnt++;
        end
        if (chan_bus.channel_value !== got_beat.value) begin
          $error("channel_value: expected %0d, actual %0d",
                 got_beat.value, chan_bus.channel_value);
          err_cnt++;
        end
        if (chan_bus.frame_flags !== got_beat.flags) begin
          $error("frame_flags: expected 0x%02h, actual 0x%02h",
                 got_beat.flags, chan_bus.frame_flags);
          err_cnt++;
        end
        if (chan_bus.last_channel !== got_beat.last) begin
          $error("last_channel: expected %0d, actual %0d",
                 got_beat.last, chan_bus.last_channel);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    rx_bus.valid = 1'b0;
    rx_bus.rx_byte = 8'h00;
    chan_bus.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, with the first idling mix.
    src_idle_pct = 29;
    snk_idle_pct = 60;
    test_noise_ignored();
    test_payload_extremes();
    test_end_byte_variants();
    test_dropped_frames();
    test_start_value_in_payload();

    // Random part: swap idling between the two sides, then run flat out.
    test_random_traffic(29, 60, 30);
    test_random_traffic(60, 29, 30);
    test_backpressure_fill();
    test_random_traffic(0, 0, 30);

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (exp_channels.size() != 0) begin
      $error("%0d channel beats never arrived", exp_channels.size());
      err_cnt++;
    end

    $display("Run covered %0d bytes (%0d parsed), %0d frames kept, %0d dropped,",
             bytes_sent, counted_items, frames_kept, frames_dropped);
    $display("and %0d channel beats compared in %0d cycles.", beats_checked, cycle_cnt);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
